// ===== src/clni_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the character LCD nibble interface.
// No dependencies; every other source file but clni_checker refers into this package.
package clni_pkg;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_DATA = 2'd1;
  localparam logic [1:0] OP_CMD  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] CFG_STROBE = 2'd0;
  localparam logic [1:0] CFG_GAP    = 2'd1;
  localparam logic [1:0] CFG_POWER  = 2'd2;
  localparam logic [1:0] CFG_CLEAR  = 2'd3;

  localparam int CFG_DATA_W = 20;

  localparam logic [7:0]  RST_STROBE = 8'd20;
  localparam logic [15:0] RST_GAP    = 16'd10000;
  localparam logic [19:0] RST_POWER  = 20'd500000;
  localparam logic [15:0] RST_CLEAR  = 16'd15000;

  localparam logic [12:0] PAUSE_LONG  = 13'd5000;
  localparam logic [12:0] PAUSE_SHORT = 13'd1000;

  localparam logic [3:0] NIB_WAKE = 4'h3;
  localparam logic [3:0] NIB_FOUR = 4'h2;

  localparam logic [3:0] STEP_RESET      = 4'd0;
  localparam logic [3:0] STEP_WAKE_FIRST = 4'd1;
  localparam logic [3:0] STEP_WAKE_LAST  = 4'd3;
  localparam logic [3:0] STEP_NIB_FOUR   = 4'd4;
  localparam logic [3:0] STEP_CMD_FIRST  = 4'd5;
  localparam logic [3:0] STEP_CMD_PREV   = 4'd7;
  localparam logic [3:0] STEP_CMD_LAST   = 4'd8;
  localparam logic [3:0] STEP_READY      = 4'd9;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_WRITE,
    KIND_SKIP
  } kind_t;

  typedef enum logic [2:0] {
    PH_POWER,
    PH_HIGH,
    PH_LOW,
    PH_GAP,
    PH_PAUSE,
    PH_CLEAR,
    PH_IDLE
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic       rs;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic                  valid;
    logic [1:0]            index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       sel;
    logic       en;
    logic       ready;
    logic       rejected;
  } result_t;

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h28;
      2'd1:    b = 8'h0e;
      2'd2:    b = 8'h06;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

endpackage

// ===== src/char_lcd_nibble_interface.sv =====
`timescale 1ns / 1ps
// Character LCD controller for a 4-bit bus: front classifier, item queue and
// back sequencer. Depends on clni_pkg, clni_front, clni_queue, clni_back.
//
// Every input beat (a one-microsecond tick, a data write, a command write)
// yields exactly one result beat carrying the LCD pin levels after that beat,
// plus ready and rejected flags. The block takes one beat per clock while
// in_stall is low; an accepted beat passes the front register, the two-entry
// queue and the back sequencer, whose per-beat update (one wait-count compare
// plus phase transitions) sets the cycle.
// After reset the sequencer runs the power-up nibbles and init commands,
// timed purely by tick beats; writes arriving before ready_res are dropped
// and flagged. Configuration writes are always accepted (cfg_ready is high)
// and should be issued only while the block is idle.
module char_lcd_nibble_interface #(
  parameter int WAIT_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_opcode,
  input  logic [7:0]                      in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [3:0]                      out_data_nibble,
  output logic                            out_reg_select,
  output logic                            out_enable,
  output logic                            out_ready_res,
  output logic                            out_rejected,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [clni_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  clni_pkg::item_t   push_item;
  clni_pkg::item_t   q_item;
  clni_pkg::cfg_wr_t cfg_wr;
  clni_pkg::result_t res;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  clni_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_value  (in_value),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  clni_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  clni_back #(
    .WAIT_BITS (WAIT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_data_nibble = res.nibble;
  assign out_reg_select  = res.sel;
  assign out_enable      = res.en;
  assign out_ready_res   = res.ready;
  assign out_rejected    = res.rejected;

endmodule

// ===== src/clni_front.sv =====
`timescale 1ns / 1ps
// Front stage: takes input beats, classifies the opcode and holds one item
// for the queue. Depends on clni_pkg.
module clni_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_opcode,
  input  logic [7:0]      in_value,
  output logic            push,
  output clni_pkg::item_t push_item,
  input  logic            q_full
);

  logic            valid_r;
  logic            valid_nxt;
  clni_pkg::item_t item_r;
  clni_pkg::item_t item_nxt;
  logic            take;

  assign in_stall  = valid_r && q_full;
  assign take      = in_valid && !in_stall;
  assign push      = valid_r && !q_full;
  assign push_item = item_r;

  always_comb begin
    item_nxt.value = in_value;
    item_nxt.rs    = 1'b0;
    unique case (in_opcode)
      clni_pkg::OP_TICK: begin
        item_nxt.kind = clni_pkg::KIND_TICK;
      end
      clni_pkg::OP_DATA: begin
        item_nxt.kind = clni_pkg::KIND_WRITE;
        item_nxt.rs   = 1'b1;
      end
      clni_pkg::OP_CMD: begin
        item_nxt.kind = clni_pkg::KIND_WRITE;
      end
      default: begin
        item_nxt.kind = clni_pkg::KIND_SKIP;
      end
    endcase
  end

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== src/clni_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of classified items between the front and back stages.
// Depends on clni_pkg for the item type and depth.
module clni_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  clni_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output clni_pkg::item_t q_item
);

  clni_pkg::item_t                  slot_r [clni_pkg::QUEUE_DEPTH];
  logic [clni_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [clni_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [clni_pkg::QCNT_W-1:0]      count_r;
  logic [clni_pkg::QCNT_W-1:0]      count_nxt;

  assign full    = count_r == clni_pkg::QCNT_W'(clni_pkg::QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign q_item  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && q_valid)) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop && q_valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && q_valid) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/clni_back.sv =====
`timescale 1ns / 1ps
// Back stage: timing registers, init sequencer, nibble strobe machine and
// the registered result beat. Depends on clni_pkg.
module clni_back #(
  parameter int WAIT_BITS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  clni_pkg::cfg_wr_t cfg_wr,
  input  logic              q_valid,
  input  clni_pkg::item_t   q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output clni_pkg::result_t out_res
);

  localparam logic [WAIT_BITS-1:0] WaitMax = '1;

  logic [7:0]  strobe_r;
  logic [15:0] gap_r;
  logic [19:0] power_r;
  logic [15:0] clear_r;

  clni_pkg::phase_t     phase_r, phase_nxt;
  logic [WAIT_BITS-1:0] wait_r, wait_nxt;
  logic [3:0]           step_r, step_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 low_r, low_nxt;
  logic                 sel_r, sel_nxt;
  logic                 en_r, en_nxt;
  logic [3:0]           nib_r, nib_nxt;
  logic                 rej_nxt;
  logic                 fin;
  logic                 fire;

  logic              out_valid_r, out_valid_nxt;
  clni_pkg::result_t res_r;

  function automatic logic [WAIT_BITS-1:0] phase_len(
    input clni_pkg::phase_t ph,
    input logic [3:0]       st,
    input logic [7:0]       sb,
    input logic [15:0]      cg,
    input logic [19:0]      pw,
    input logic [15:0]      cw
  );
    logic [32:0] d;
    logic [32:0] lim;
    lim = 33'({1'b0, 32'hFFFF_FFFF} >> (32 - WAIT_BITS));
    unique case (ph)
      clni_pkg::PH_POWER: d = 33'(pw);
      clni_pkg::PH_HIGH,
      clni_pkg::PH_LOW:   d = (sb == 8'd0) ? 33'd1 : 33'(sb);
      clni_pkg::PH_GAP:   d = 33'(cg);
      clni_pkg::PH_PAUSE: d = (st >= clni_pkg::STEP_WAKE_LAST) ?
                              33'(clni_pkg::PAUSE_SHORT) : 33'(clni_pkg::PAUSE_LONG);
      clni_pkg::PH_CLEAR: d = 33'(cw);
      default:            d = '0;
    endcase
    if (d > lim) begin
      d = lim;
    end
    return d[WAIT_BITS-1:0];
  endfunction

  assign fire      = q_valid && (!out_valid_r || !out_stall);
  assign q_pop     = fire;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    step_nxt  = step_r;
    byte_nxt  = byte_r;
    low_nxt   = low_r;
    sel_nxt   = sel_r;
    en_nxt    = en_r;
    nib_nxt   = nib_r;
    rej_nxt   = 1'b0;
    fin       = 1'b0;

    unique case (q_item.kind)
      clni_pkg::KIND_TICK: begin
        if (phase_nxt != clni_pkg::PH_IDLE) begin
          if (wait_nxt != WaitMax) begin
            wait_nxt = wait_nxt + 1'b1;
          end
          fin = wait_nxt >= phase_len(phase_nxt, step_nxt, strobe_r, gap_r,
                                      power_r, clear_r);
        end
      end
      clni_pkg::KIND_WRITE: begin
        if (phase_nxt == clni_pkg::PH_IDLE) begin
          wait_nxt  = '0;
          byte_nxt  = q_item.value;
          low_nxt   = 1'b0;
          sel_nxt   = q_item.rs;
          nib_nxt   = q_item.value[7:4];
          en_nxt    = 1'b1;
          phase_nxt = clni_pkg::PH_HIGH;
        end else begin
          rej_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // zero-length gap and clear phases fall through in the same beat
    for (int i = 0; i < 4; i++) begin
      if (fin) begin
        wait_nxt = '0;
        unique case (phase_nxt)
          clni_pkg::PH_POWER: begin
            step_nxt  = clni_pkg::STEP_WAKE_FIRST;
            sel_nxt   = 1'b0;
            nib_nxt   = clni_pkg::NIB_WAKE;
            en_nxt    = 1'b1;
            phase_nxt = clni_pkg::PH_HIGH;
          end
          clni_pkg::PH_HIGH: begin
            en_nxt    = 1'b0;
            phase_nxt = clni_pkg::PH_LOW;
          end
          clni_pkg::PH_LOW: begin
            if (step_nxt >= clni_pkg::STEP_WAKE_FIRST &&
                step_nxt <= clni_pkg::STEP_NIB_FOUR) begin
              sel_nxt = 1'b1;
              if (step_nxt <= clni_pkg::STEP_WAKE_LAST) begin
                phase_nxt = clni_pkg::PH_PAUSE;
              end else begin
                step_nxt  = clni_pkg::STEP_CMD_FIRST;
                byte_nxt  = clni_pkg::init_byte(2'd0);
                low_nxt   = 1'b0;
                sel_nxt   = 1'b0;
                nib_nxt   = byte_nxt[7:4];
                en_nxt    = 1'b1;
                phase_nxt = clni_pkg::PH_HIGH;
              end
            end else if (!low_nxt) begin
              low_nxt   = 1'b1;
              nib_nxt   = byte_nxt[3:0];
              en_nxt    = 1'b1;
              phase_nxt = clni_pkg::PH_HIGH;
            end else begin
              phase_nxt = clni_pkg::PH_GAP;
            end
          end
          clni_pkg::PH_GAP: begin
            sel_nxt = 1'b1;
            if (step_nxt >= clni_pkg::STEP_CMD_FIRST &&
                step_nxt <= clni_pkg::STEP_CMD_PREV) begin
              step_nxt  = step_nxt + 1'b1;
              byte_nxt  = clni_pkg::init_byte(2'(step_nxt - clni_pkg::STEP_CMD_FIRST));
              low_nxt   = 1'b0;
              sel_nxt   = 1'b0;
              nib_nxt   = byte_nxt[7:4];
              en_nxt    = 1'b1;
              phase_nxt = clni_pkg::PH_HIGH;
            end else if (step_nxt == clni_pkg::STEP_CMD_LAST) begin
              phase_nxt = clni_pkg::PH_CLEAR;
            end else begin
              step_nxt  = clni_pkg::STEP_READY;
              phase_nxt = clni_pkg::PH_IDLE;
            end
          end
          clni_pkg::PH_PAUSE: begin
            step_nxt  = step_nxt + 1'b1;
            sel_nxt   = 1'b0;
            nib_nxt   = (step_nxt == clni_pkg::STEP_NIB_FOUR) ?
                        clni_pkg::NIB_FOUR : clni_pkg::NIB_WAKE;
            en_nxt    = 1'b1;
            phase_nxt = clni_pkg::PH_HIGH;
          end
          clni_pkg::PH_CLEAR: begin
            step_nxt  = clni_pkg::STEP_READY;
            phase_nxt = clni_pkg::PH_IDLE;
          end
          default: begin
            phase_nxt = clni_pkg::PH_IDLE;
          end
        endcase
        fin = (phase_nxt != clni_pkg::PH_IDLE) &&
              (phase_len(phase_nxt, step_nxt, strobe_r, gap_r, power_r,
                         clear_r) == '0);
      end
    end
  end

  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= clni_pkg::RST_STROBE;
      gap_r    <= clni_pkg::RST_GAP;
      power_r  <= clni_pkg::RST_POWER;
      clear_r  <= clni_pkg::RST_CLEAR;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        clni_pkg::CFG_STROBE: strobe_r <= cfg_wr.data[7:0];
        clni_pkg::CFG_GAP:    gap_r    <= cfg_wr.data[15:0];
        clni_pkg::CFG_POWER:  power_r  <= cfg_wr.data;
        clni_pkg::CFG_CLEAR:  clear_r  <= cfg_wr.data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= clni_pkg::PH_POWER;
      wait_r      <= '0;
      step_r      <= clni_pkg::STEP_RESET;
      byte_r      <= '0;
      low_r       <= 1'b0;
      sel_r       <= 1'b1;
      en_r        <= 1'b0;
      nib_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        phase_r <= phase_nxt;
        wait_r  <= wait_nxt;
        step_r  <= step_nxt;
        byte_r  <= byte_nxt;
        low_r   <= low_nxt;
        sel_r   <= sel_nxt;
        en_r    <= en_nxt;
        nib_r   <= nib_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r.nibble   <= nib_nxt;
      res_r.sel      <= sel_nxt;
      res_r.en       <= en_nxt;
      res_r.ready    <= phase_nxt == clni_pkg::PH_IDLE;
      res_r.rejected <= rej_nxt;
    end
  end

endmodule

// ===== src/clni_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for char_lcd_nibble_interface, attached by bind.
// Depends only on the top level's port names.
module clni_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_data_nibble,
  input logic       out_reg_select,
  input logic       out_enable,
  input logic       out_ready_res,
  input logic       out_rejected
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_nibble) &&
      $stable(out_reg_select) && $stable(out_enable) &&
      $stable(out_ready_res) && $stable(out_rejected))
    else $error("result beat changed while stalled");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> !out_ready_res)
    else $error("write rejected while ready");

  a_ready_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready_res |-> out_reg_select && !out_enable)
    else $error("ready with select low or enable high");

endmodule

bind char_lcd_nibble_interface clni_checker u_clni_checker (.*);

// ===== bench/char_lcd_nibble_interface_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for char_lcd_nibble_interface: a clocked driver and monitor
// compare every result beat with a built-in model of the LCD power-up and byte timing.
// Depends on clni_pkg and the char_lcd_nibble_interface RTL.
module char_lcd_nibble_interface_test;
  import clni_pkg::*;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] value;
  } lcd_req_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic [1:0]            in_opcode  = OP_TICK;
  logic [7:0]            in_value   = 8'h00;
  logic                  out_stall  = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [1:0]            cfg_index  = CFG_STROBE;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic [3:0]            out_data_nibble;
  logic                  out_reg_select;
  logic                  out_enable;
  logic                  out_ready_res;
  logic                  out_rejected;
  logic                  cfg_ready;

  char_lcd_nibble_interface dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_nibble (out_data_nibble),
    .out_reg_select  (out_reg_select),
    .out_enable      (out_enable),
    .out_ready_res   (out_ready_res),
    .out_rejected    (out_rejected),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model copy of the registers
  logic [7:0]  strobe_us = RST_STROBE;
  logic [15:0] gap_us    = RST_GAP;
  logic [19:0] power_us  = RST_POWER;
  logic [15:0] clear_us  = RST_CLEAR;

  // model copy of the sequencer
  phase_t      lcd_phase  = PH_POWER;
  logic [19:0] elapsed_us = '0;
  logic [3:0]  setup_step = STEP_RESET;
  logic [7:0]  byte_hold  = 8'h00;
  logic        second_half = 1'b0;
  logic [3:0]  pin_nib    = 4'h0;
  logic        pin_sel    = 1'b1;
  logic        pin_en     = 1'b0;

  lcd_req_t req_queue[$];
  result_t  pin_levels_due[$];

  logic     idle_on         = 1'b0;
  logic     long_hold_armed = 1'b0;
  logic     long_hold_done  = 1'b0;
  int       send_gap        = 0;
  int       hold_left       = 0;
  int       mismatches      = 0;
  int       results_seen    = 0;
  int       settings_used   = 0;
  lcd_req_t next_req;
  result_t  due_now;
  result_t  want;

  function automatic logic [7:0] setup_cmd(input int k);
    logic [7:0] b;
    case (k)
      0:       b = 8'h28;
      1:       b = 8'h0e;
      2:       b = 8'h06;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

  function automatic logic [19:0] phase_len();
    logic [19:0] d;
    case (lcd_phase)
      PH_POWER:        d = power_us;
      PH_HIGH, PH_LOW: d = (strobe_us == 8'd0) ? 20'd1 : {12'd0, strobe_us};
      PH_GAP:          d = {4'd0, gap_us};
      PH_PAUSE:        d = (setup_step >= STEP_WAKE_LAST) ? {7'd0, PAUSE_SHORT}
                                                          : {7'd0, PAUSE_LONG};
      PH_CLEAR:        d = {4'd0, clear_us};
      default:         d = '0;
    endcase
    return d;
  endfunction

  function automatic void open_nibble(input logic [3:0] nib);
    pin_nib   = nib;
    pin_en    = 1'b1;
    lcd_phase = PH_HIGH;
  endfunction

  function automatic void open_byte(input logic [7:0] b, input logic rs);
    byte_hold   = b;
    second_half = 1'b0;
    pin_sel     = rs;
    open_nibble(b[7:4]);
  endfunction

  function automatic void close_phase();
    elapsed_us = '0;
    case (lcd_phase)
      PH_POWER: begin
        setup_step = STEP_WAKE_FIRST;
        pin_sel    = 1'b0;
        open_nibble(NIB_WAKE);
      end
      PH_HIGH: begin
        pin_en    = 1'b0;
        lcd_phase = PH_LOW;
      end
      PH_LOW: begin
        if (setup_step >= STEP_WAKE_FIRST && setup_step <= STEP_NIB_FOUR) begin
          pin_sel = 1'b1;
          if (setup_step <= STEP_WAKE_LAST) begin
            lcd_phase = PH_PAUSE;
          end else begin
            setup_step = STEP_CMD_FIRST;
            open_byte(setup_cmd(0), 1'b0);
          end
        end else if (!second_half) begin
          second_half = 1'b1;
          open_nibble(byte_hold[3:0]);
        end else begin
          lcd_phase = PH_GAP;
        end
      end
      PH_GAP: begin
        pin_sel = 1'b1;
        if (setup_step >= STEP_CMD_FIRST && setup_step <= STEP_CMD_PREV) begin
          setup_step = setup_step + 4'd1;
          open_byte(setup_cmd(int'(setup_step - STEP_CMD_FIRST)), 1'b0);
        end else if (setup_step == STEP_CMD_LAST) begin
          lcd_phase = PH_CLEAR;
        end else begin
          setup_step = STEP_READY;
          lcd_phase  = PH_IDLE;
        end
      end
      PH_PAUSE: begin
        setup_step = setup_step + 4'd1;
        pin_sel    = 1'b0;
        open_nibble(setup_step == STEP_NIB_FOUR ? NIB_FOUR : NIB_WAKE);
      end
      PH_CLEAR: begin
        setup_step = STEP_READY;
        lcd_phase  = PH_IDLE;
      end
      default: lcd_phase = PH_IDLE;
    endcase
  endfunction

  // pin levels and flags after one beat
  function automatic result_t advance_lcd(input logic [1:0] op, input logic [7:0] val);
    result_t r;
    int      g;
    r.rejected = 1'b0;
    if (op == OP_TICK) begin
      if (lcd_phase != PH_IDLE) begin
        if (elapsed_us != '1) elapsed_us = elapsed_us + 20'd1;
        if (elapsed_us >= phase_len()) begin
          close_phase();
          for (g = 0; g < 16 && lcd_phase != PH_IDLE && phase_len() == '0; g++)
            close_phase();
        end
      end
    end else if (op == OP_DATA || op == OP_CMD) begin
      if (lcd_phase == PH_IDLE) begin
        elapsed_us = '0;
        open_byte(val, op == OP_DATA);
      end else begin
        r.rejected = 1'b1;
      end
    end
    r.nibble = pin_nib;
    r.sel    = pin_sel;
    r.en     = pin_en;
    r.ready  = (lcd_phase == PH_IDLE);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      send_gap    = 0;
      lcd_phase   = PH_POWER;
      elapsed_us  = '0;
      setup_step  = STEP_RESET;
      byte_hold   = 8'h00;
      second_half = 1'b0;
      pin_nib     = 4'h0;
      pin_sel     = 1'b1;
      pin_en      = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_now = advance_lcd(in_opcode, in_value);
        pin_levels_due.push_back(due_now);
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          next_req = req_queue.pop_front();
          in_valid  <= 1'b1;
          in_opcode <= next_req.opcode;
          in_value  <= next_req.value;
          if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pin_levels_due.size() == 0) begin
          $display("%0t: result beat mismatch, expected none, got %0h %0h %0h %0h %0h",
                   $time, out_data_nibble, out_reg_select, out_enable, out_ready_res,
                   out_rejected);
          mismatches++;
        end else begin
          want = pin_levels_due.pop_front();
          check_field("data_nibble", want.nibble, out_data_nibble);
          check_field("reg_select", want.sel, out_reg_select);
          check_field("enable", want.en, out_enable);
          check_field("ready_res", want.ready, out_ready_res);
          check_field("rejected", want.rejected, out_rejected);
        end
      end
      if (long_hold_armed && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left      = 60;
      end else if (hold_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(1, 11);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void push_req(input logic [1:0] op, input logic [7:0] val);
    req_queue.push_back('{op, val});
  endfunction

  function automatic void push_ticks(input int n);
    for (int i = 0; i < n; i++) push_req(OP_TICK, 8'($urandom_range(0, 255)));
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (req_queue.size() != 0 || in_valid || pin_levels_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_until_ready(input int chunk);
    drain();
    while (lcd_phase != PH_IDLE) begin
      push_ticks(chunk);
      drain();
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_STROBE: strobe_us = val[7:0];
      CFG_GAP:    gap_us    = val[15:0];
      CFG_POWER:  power_us  = val;
      CFG_CLEAR:  clear_us  = val[15:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [7:0] s, input logic [15:0] g,
                              input logic [19:0] p, input logic [15:0] c);
    @(posedge clk);
    cfg_write(CFG_STROBE, {12'd0, s});
    cfg_write(CFG_GAP, {4'd0, g});
    cfg_write(CFG_POWER, p);
    cfg_write(CFG_CLEAR, {4'd0, c});
    cfg_valid <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  initial begin
    int counted;
    int pick;
    counted = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // zero power-on, gap and clear waits; zero strobe acts as one
    program_regs(8'd0, 16'd0, 20'd0, 16'd0);
    idle_on = 1'b1;
    for (int i = 0; i < 200; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) push_req(OP_DATA, 8'($urandom_range(0, 255)));
      else if (pick == 1) push_req(OP_CMD, 8'($urandom_range(0, 255)));
      else if (pick == 2) push_req(OP_NONE, 8'($urandom_range(0, 255)));
      else push_req(OP_TICK, 8'($urandom_range(0, 255)));
    end
    run_until_ready(512);

    push_req(OP_TICK, 8'hff);
    push_req(OP_NONE, 8'hff);
    push_req(OP_DATA, 8'h00);
    push_req(OP_CMD, 8'hff);
    push_ticks(5);
    push_req(OP_CMD, 8'hff);
    push_req(OP_DATA, 8'h5a);
    push_ticks(5);
    push_req(OP_DATA, 8'ha5);
    push_ticks(4);
    push_req(OP_CMD, 8'h5a);
    push_ticks(4);
    run_until_ready(16);

    while (counted < 600) begin
      program_regs(8'($urandom_range(0, 3)), 16'($urandom_range(0, 8)),
                   20'($urandom), 16'($urandom));
      long_hold_armed = 1'b1;
      for (int i = 0; i < 120; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          push_req(OP_NONE, 8'($urandom_range(0, 255)));
        end else begin
          if (pick < 20)
            push_req($urandom_range(0, 1) ? OP_DATA : OP_CMD, 8'($urandom_range(0, 255)));
          else
            push_req(OP_TICK, 8'($urandom_range(0, 255)));
          counted++;
        end
      end
      run_until_ready(32);
    end

    // longest strobe and byte gap, widest power and clear values, no idling
    idle_on = 1'b0;
    program_regs(8'd255, 16'hffff, 20'hfffff, 16'hffff);
    push_req(OP_DATA, 8'($urandom_range(0, 255)));
    push_req(OP_CMD, 8'($urandom_range(0, 255)));
    push_req(OP_NONE, 8'($urandom_range(0, 255)));
    run_until_ready(4096);
    push_req(OP_TICK, 8'h00);
    drain();

    $display("covered power-up with zero waits, %0d random beats over %0d register settings,",
             counted, settings_used);
    $display("busy drops, unused opcodes and the longest strobe and gap; %0d results checked",
             results_seen);
    if (mismatches == 0 && pin_levels_due.size() == 0) begin
      $display("char_lcd_nibble_interface verification clean");
    end else begin
      $display("char_lcd_nibble_interface verification failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("char_lcd_nibble_interface verification failed");
    $finish;
  end

endmodule
